@@ design/ksit_pkg.sv @@
`default_nettype none
package ksit_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;

  localparam int ITEM_W  = 16;
  localparam int KEY_W   = 4;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] CAT_UNKNOWN = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    key_t              key;
  } entry_t;

  // Control from the top level into one cell.
  typedef struct packed {
    logic insert;
    logic valid;
    logic prev_le;
    logic rd_sel;
  } cell_ctl_t;

  // Compare flags that one cell reports.
  typedef struct packed {
    logic le;
    logic bnd;
  } cell_flag_t;

endpackage
`default_nettype wire

@@ design/ksit_cell.sv @@
`default_nettype none
module ksit_cell import ksit_pkg::*; (
  input  wire logic       clk,
  input  wire cell_ctl_t  ctl,
  input  wire entry_t     prev_entry,
  input  wire entry_t     new_entry,
  output entry_t          entry,
  output cell_flag_t      flag,
  output entry_t          rd_entry
);

  entry_t stored;

  always_comb begin
    // A valid entry whose key is not above the new key stays where it is.
    flag.le  = ctl.valid && (stored.key <= new_entry.key);
    flag.bnd = ctl.prev_le && !flag.le;
  end

  always_ff @(posedge clk) begin
    if (ctl.insert && !flag.le) begin
      if (ctl.prev_le) begin
        stored <= new_entry;
      end else begin
        stored <= prev_entry;
      end
    end
  end

  assign entry    = stored;
  assign rd_entry = ctl.rd_sel ? stored : '0;

endmodule
`default_nettype wire

@@ design/keyed_sorted_insert_table.sv @@
// Keyed sorted insert table.
// Commands arrive on the cmd channel (cmd_valid/cmd_ready) with fields cmd,
// item_id, category, rank and read_index. Every command produces exactly one
// result on the rsp channel (rsp_valid/rsp_ready) with status,
// insert_position, entry_count, read_item, read_category and read_rank.
// The table is a row of TABLE_DEPTH cells. On an add, every cell compares its
// key with the new key in the same cycle and either holds, loads the new
// item, or takes its lower neighbor's entry, so the whole row is updated at
// once. A read selects one cell and captures its entry into the result
// register when the command is accepted.
// rsp_valid rises in the cycle after the command transfer. While the receiver
// takes each result, one command can be taken per cycle (single result register).
// cmd_ready is high while the result register is empty or its result is
// being taken, so a stalled receiver holds off further commands.
// Reset clears the entry count and the result valid flag; the cell contents
// are left as they are and are never read before they are written.
`default_nettype none
module keyed_sorted_insert_table import ksit_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire logic               cmd,
  input  wire logic [ITEM_W-1:0]  item_id,
  input  wire logic [1:0]         category,
  input  wire logic [1:0]         rank,
  input  wire logic [INDEX_W-1:0] read_index,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output logic [1:0]              status,
  output logic [COUNT_W-1:0]      insert_position,
  output logic [COUNT_W-1:0]      entry_count,
  output logic [ITEM_W-1:0]       read_item,
  output logic [1:0]              read_category,
  output logic [1:0]              read_rank
);

  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int PW   = $clog2(TABLE_DEPTH);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int EW   = ITEM_W + KEY_W;

  logic [CW-1:0] fill_count;
  logic [CW-1:0] fill_count_next;

  logic accept;
  logic is_add;
  logic drop;
  logic full;
  logic do_insert;
  logic in_range;

  entry_t new_entry;

  entry_t     cell_entry [TABLE_DEPTH];
  entry_t     cell_rd    [TABLE_DEPTH];
  cell_ctl_t  cell_ctl   [TABLE_DEPTH];
  cell_flag_t cell_flag  [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] bnd_vec;
  logic [TABLE_DEPTH-1:0] pos_mask [PW];
  logic [TABLE_DEPTH-1:0] rd_col   [EW];
  logic [PW-1:0]          pos;
  entry_t                 rd_entry;

  logic [1:0] status_next;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign is_add    = (cmd == CMD_ADD);
  assign drop      = (category == CAT_UNKNOWN);
  assign full      = (fill_count == CW'(TABLE_DEPTH));
  assign do_insert = accept && is_add && !drop && !full;
  assign in_range  = CMPW'(read_index) < CMPW'(fill_count);

  assign new_entry.item = item_id;
  assign new_entry.key  = {category, rank};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign cell_ctl[i].insert  = do_insert;
    assign cell_ctl[i].valid   = CW'(i) < fill_count;
    assign cell_ctl[i].rd_sel  = cell_ctl[i].valid && (CMPW'(i) == CMPW'(read_index));
    if (i == 0) begin : g_first
      assign cell_ctl[i].prev_le = 1'b1;
      ksit_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .prev_entry (new_entry),
        .new_entry  (new_entry),
        .entry      (cell_entry[i]),
        .flag       (cell_flag[i]),
        .rd_entry   (cell_rd[i])
      );
    end else begin : g_rest
      assign cell_ctl[i].prev_le = cell_flag[i-1].le;
      ksit_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .prev_entry (cell_entry[i-1]),
        .new_entry  (new_entry),
        .entry      (cell_entry[i]),
        .flag       (cell_flag[i]),
        .rd_entry   (cell_rd[i])
      );
    end
    assign bnd_vec[i] = cell_flag[i].bnd;
    for (genvar k = 0; k < PW; k++) begin : g_mask
      assign pos_mask[k][i] = 1'((i >> k) & 1);
    end
    for (genvar b = 0; b < EW; b++) begin : g_col
      assign rd_col[b][i] = cell_rd[i][b];
    end
  end

  // While the table is not full the boundary flag is one-hot: exactly one cell sits
  // right after the last entry that keeps its place, so its index is an OR of masked bits.
  for (genvar k = 0; k < PW; k++) begin : g_pos
    assign pos[k] = |(bnd_vec & pos_mask[k]);
  end

  for (genvar b = 0; b < EW; b++) begin : g_rd
    assign rd_entry[b] = |rd_col[b];
  end

  always_comb begin
    fill_count_next = fill_count;
    if (do_insert) begin
      fill_count_next = fill_count + CW'(1);
    end
    if (is_add) begin
      if (drop) begin
        status_next = ST_DROP;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_OK;
      end
    end else begin
      status_next = in_range ? ST_OK : ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status          <= status_next;
      entry_count     <= COUNT_W'(fill_count_next);
      insert_position <= do_insert ? COUNT_W'(pos) : '0;
      if (is_add) begin
        read_item     <= '0;
        read_category <= '0;
        read_rank     <= '0;
      end else begin
        read_item     <= rd_entry.item;
        read_category <= rd_entry.key[3:2];
        read_rank     <= rd_entry.key[1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ design/ksit_checker.sv @@
`default_nettype none
module ksit_checker import ksit_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cmd_valid,
  input wire logic               cmd_ready,
  input wire logic               cmd,
  input wire logic [ITEM_W-1:0]  item_id,
  input wire logic [1:0]         category,
  input wire logic [1:0]         rank,
  input wire logic [INDEX_W-1:0] read_index,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic [1:0]         status,
  input wire logic [COUNT_W-1:0] insert_position,
  input wire logic [COUNT_W-1:0] entry_count,
  input wire logic [ITEM_W-1:0]  read_item,
  input wire logic [1:0]         read_category,
  input wire logic [1:0]         read_rank
);

  // A result that waits must keep its status, entry count, insert position and read item until the transfer.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_count)
      && $stable(insert_position) && $stable(read_item))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // A refused add reports the table at its full depth.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> entry_count == COUNT_W'(TABLE_DEPTH)
      && insert_position == '0)
    else $error("full status with wrong count");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_DROP |-> insert_position == '0 && read_item == '0
      && read_category == '0 && read_rank == '0)
    else $error("dropped add with nonzero fields");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_RANGE |-> read_item == '0 && read_category == '0
      && read_rank == '0 && insert_position == '0)
    else $error("out of range read with nonzero fields");

endmodule

bind keyed_sorted_insert_table ksit_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_ksit_checker (.*);
`default_nettype wire

@@ test/keyed_sorted_insert_table_tb.sv @@
`default_nettype none
module keyed_sorted_insert_table_tb;
  import ksit_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]         status;
    logic [COUNT_W-1:0] position;
    logic [COUNT_W-1:0] count;
    logic [ITEM_W-1:0]  item;
    logic [1:0]         cat;
    logic [1:0]         rnk;
  } table_rsp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_ready;
  logic               cmd = CMD_READ;
  logic [ITEM_W-1:0]  item_id = '0;
  logic [1:0]         category = '0;
  logic [1:0]         rank = '0;
  logic [INDEX_W-1:0] read_index = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic [1:0]         status;
  logic [COUNT_W-1:0] insert_position;
  logic [COUNT_W-1:0] entry_count;
  logic [ITEM_W-1:0]  read_item;
  logic [1:0]         read_category;
  logic [1:0]         read_rank;

  // Shadow copy of the table, updated in transfer order.
  logic [ITEM_W-1:0] shadow_items [DEPTH];
  key_t              shadow_keys  [DEPTH];
  int                shadow_fill = 0;

  table_rsp_t pending_rsp [$];
  int         errors = 0;
  int         cycle_count = 0;
  logic       steady = 1'b0;
  logic       hold_go = 1'b0;
  logic       rsp_hold = 1'b0;

  keyed_sorted_insert_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .item_id(item_id), .category(category), .rank(rank),
    .read_index(read_index),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .insert_position(insert_position), .entry_count(entry_count),
    .read_item(read_item), .read_category(read_category), .read_rank(read_rank)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Applies one command to the shadow table and returns the response it must produce.
  function automatic table_rsp_t predict_table_cmd(input logic c, input logic [ITEM_W-1:0] id,
                                                   input logic [1:0] cat, input logic [1:0] rk,
                                                   input logic [INDEX_W-1:0] idx);
    table_rsp_t r;
    key_t       k;
    int         p;
    int         i;
    r = '{status: ST_OK, position: '0, count: '0, item: '0, cat: '0, rnk: '0};
    if (c == CMD_ADD) begin
      if (cat == CAT_UNKNOWN) begin
        r.status = ST_DROP;
      end else if (shadow_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        k = {cat, rk};
        p = 0;
        // Equal keys stay ahead of the new item, which keeps arrival order in a bucket.
        while (p < shadow_fill && shadow_keys[p] <= k) p++;
        for (i = shadow_fill; i > p; i--) begin
          shadow_items[i] = shadow_items[i-1];
          shadow_keys[i]  = shadow_keys[i-1];
        end
        shadow_items[p] = id;
        shadow_keys[p]  = k;
        shadow_fill++;
        r.position = COUNT_W'(p);
      end
    end else begin
      if (idx >= shadow_fill) begin
        r.status = ST_RANGE;
      end else begin
        r.item = shadow_items[idx];
        r.cat  = shadow_keys[idx][3:2];
        r.rnk  = shadow_keys[idx][1:0];
      end
    end
    r.count = COUNT_W'(shadow_fill);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [ITEM_W-1:0] want,
                             input logic [ITEM_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Response side: checks each transfer and idles at random.
  always @(posedge clk) begin : rsp_monitor
    table_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual status %0d count %0d",
                 $time, status, entry_count);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", ITEM_W'(want.status), ITEM_W'(status));
        check_field("insert_position", ITEM_W'(want.position), ITEM_W'(insert_position));
        check_field("entry_count", ITEM_W'(want.count), ITEM_W'(entry_count));
        check_field("read_item", want.item, read_item);
        check_field("read_category", ITEM_W'(want.cat), ITEM_W'(read_category));
        check_field("read_rank", ITEM_W'(want.rnk), ITEM_W'(read_rank));
      end
    end
    rsp_ready <= !rsp_hold && (steady || $urandom_range(99) >= 24);
  end

  // Long receiver hold-off, started once by the backpressure test.
  initial begin
    wait (hold_go);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  task automatic send_cmd(input logic c, input logic [ITEM_W-1:0] id, input logic [1:0] cat,
                          input logic [1:0] rk, input logic [INDEX_W-1:0] idx);
    while (!steady && $urandom_range(99) < 24) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid  <= 1'b1;
    cmd        <= c;
    item_id    <= id;
    category   <= cat;
    rank       <= rk;
    read_index <= idx;
    do @(posedge clk); while (!cmd_ready);
    pending_rsp.push_back(predict_table_cmd(c, id, cat, rk, idx));
  endtask

  task automatic send_random(input int add_pct);
    logic               c;
    logic [1:0]         cat;
    logic [INDEX_W-1:0] idx;
    c = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_READ;
    cat = ($urandom_range(99) < 10) ? CAT_UNKNOWN : 2'($urandom_range(2));
    if (shadow_fill > 0 && $urandom_range(99) < 80) idx = INDEX_W'($urandom_range(shadow_fill - 1));
    else idx = INDEX_W'($urandom_range(DEPTH - 1));
    send_cmd(c, ITEM_W'($urandom_range(16'hFFFF)), cat, 2'($urandom_range(3)), idx);
  endtask

  task automatic drain_responses;
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic test_empty_table;
    send_cmd(CMD_READ, 16'h0000, 2'd0, 2'd0, 6'd0);
    send_cmd(CMD_READ, 16'hFFFF, 2'd3, 2'd3, 6'd63);
    send_cmd(CMD_ADD, 16'hFFFF, CAT_UNKNOWN, 2'd3, 6'd0);
  endtask

  // Inserts at the front, the back and the middle, with repeats in one bucket, then reads back, also past the end.
  task automatic test_bucket_order;
    int i;
    send_cmd(CMD_ADD, 16'hFFFF, 2'd2, 2'd3, 6'd0);
    send_cmd(CMD_ADD, 16'h0000, 2'd0, 2'd0, 6'd63);
    send_cmd(CMD_ADD, 16'h1234, 2'd1, 2'd2, 6'd0);
    send_cmd(CMD_ADD, 16'h5678, 2'd1, 2'd2, 6'd0);
    send_cmd(CMD_ADD, 16'h0001, 2'd0, 2'd0, 6'd0);
    send_cmd(CMD_ADD, 16'hA5A5, 2'd2, 2'd0, 6'd0);
    send_cmd(CMD_ADD, 16'h8000, 2'd0, 2'd3, 6'd0);
    send_cmd(CMD_ADD, 16'h7FFF, 2'd1, 2'd1, 6'd0);
    send_cmd(CMD_ADD, 16'h4321, CAT_UNKNOWN, 2'd1, 6'd0);
    for (i = 0; i < 10; i++) begin
      send_cmd(CMD_READ, ITEM_W'($urandom_range(16'hFFFF)), 2'd3, 2'd3, INDEX_W'(i));
    end
    send_cmd(CMD_READ, 16'h0000, 2'd0, 2'd0, 6'd63);
  endtask

  task automatic test_fill_to_capacity;
    while (shadow_fill < DEPTH) send_random(65);
    repeat (12) send_random(65);
    drain_responses();
  endtask

  task automatic test_backpressure;
    int i;
    hold_go = 1'b1;
    for (i = 0; i < 40; i++) send_random(30);
  endtask

  task automatic test_steady_stream;
    int i;
    steady = 1'b1;
    for (i = 0; i < 300; i++) send_random(30);
    steady = 1'b0;
  endtask

  task automatic test_random_mix;
    int i;
    for (i = 0; i < 1200; i++) begin
      send_random(30);
      if (i % 200 == 199) drain_responses();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_bucket_order();
    test_fill_to_capacity();
    test_backpressure();
    test_steady_stream();
    test_random_mix();
    drain_responses();
    repeat (5) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
design/ksit_pkg.sv
design/ksit_cell.sv
design/keyed_sorted_insert_table.sv
design/ksit_checker.sv
test/keyed_sorted_insert_table_tb.sv
